// File: hdl/bif_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and the exp2 fraction table function
// for the bilateral image filter; no dependencies

package bif_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int SCALE_W     = 24;
  localparam int DC_W        = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_THREE_CH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_SCALE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_SCALE = 3'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_CWAIT,
    ST_TAPS,
    ST_FLUSH,
    ST_DIV,
    ST_DONE
  } bif_state_t;

  // settings the tap unit holds steady over one output pixel
  typedef struct packed {
    logic               three_ch;
    logic [SCALE_W-1:0] color_scale;
    logic [SCALE_W-1:0] space_scale;
    logic [23:0]        centre;
  } bif_tap_ctl_t;

  // exp(-t) in q0.16 for t in q0.32, 15-term taylor series, elaboration only
  function automatic logic [15:0] frac_value(input logic [63:0] t);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    term = 64'h1_0000_0000;
    sum  = term;
    for (int n = 1; n <= 14; n++) begin
      term = (term * t) >> 32;
      case (n)
        1:  term = term / 1;
        2:  term = term / 2;
        3:  term = term / 3;
        4:  term = term / 4;
        5:  term = term / 5;
        6:  term = term / 6;
        7:  term = term / 7;
        8:  term = term / 8;
        9:  term = term / 9;
        10: term = term / 10;
        11: term = term / 11;
        12: term = term / 12;
        13: term = term / 13;
        14: term = term / 14;
        default: term = term;
      endcase
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = (sum + 64'd32768) >> 16;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// File: hdl/bilateral_image_filter.sv
`timescale 1ns / 1ps
// bilateral image filter top level: config registers, raster counters,
// line ring and tap sequencer; uses bif_pkg, bif_line_store, bif_tap_unit, bif_divider
//
// usage
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   a write to a known register restarts the frame, all counters go to zero
// - input channel: one beat per pixel (opcode pixel) in raster order, or a
//   drain beat (opcode drain) to flush one pending output after the last row
// - output channel: one beat per filtered pixel, frame_last on the last one
// - a pixel beat produces an output once radius rows lie below the centre;
//   drain beats produce the final radius rows
// - per output the sequencer reads the centre pixel, walks every tap of the
//   (2R+1) by (2R+1) window, flushes the tap pipeline, runs the divider and
//   loads the output register; the next beat is taken only once the
//   sequencer is back in idle; the tap walk goes through the single
//   shared weight unit
// - pixels that produce no output are written to the line ring and leave the sequencer idle
// - in_ready is high only while the sequencer is idle; a finished result sits
//   in the output register, so the next beat is taken while it waits
// - when the receiver stalls and the output register is still full, the next
//   result waits in the sequencer until the register frees up
// - reset: counters to zero, registers to 640x480, radius 2, mono,
//   color scale 65536, space scale 2097152; the line ring is not cleared

module bilateral_image_filter #(
  parameter int MAX_RADIUS           = 3,
  parameter int MAX_WIDTH            = 1024,
  parameter int FRACTION_TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bif_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bif_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [7:0]                       in_ch0,
  input  logic [7:0]                       in_ch1,
  input  logic [7:0]                       in_ch2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_ch0,
  output logic [7:0]                       out_ch1,
  output logic [7:0]                       out_ch2,
  output logic                             frame_last
);
  import bif_pkg::*;

  localparam int SLOTS   = 2 * MAX_RADIUS + 1;
  localparam int DEPTH   = SLOTS * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(SLOTS);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int KW      = RW + 1;
  localparam int DS_W    = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int TAP_MAX = SLOTS * SLOTS;
  localparam int WSUM_W  = 16 + $clog2(TAP_MAX + 1);
  localparam int ACC_W   = WSUM_W + 8;
  localparam int NUM_W   = ACC_W + 1;
  localparam int XW      = COL_W + 2;
  localparam int YW      = 18;
  localparam int YSW     = SW + KW + 1;

  // configuration registers
  logic [10:0]        image_width;
  logic [15:0]        image_height;
  logic [1:0]         radius;
  logic               three_channel;
  logic [SCALE_W-1:0] color_scale;
  logic [SCALE_W-1:0] space_scale;

  // raster counters
  logic [COL_W-1:0] in_column, out_column;
  logic [15:0]      in_row, out_row;
  logic [SW-1:0]    in_slot, out_slot;

  // latched centre of the pixel being filtered
  logic [COL_W-1:0] ci;
  logic [15:0]      cj;
  logic [SW-1:0]    cslot;
  logic             flast;
  logic [23:0]      centre;

  // tap walk
  logic signed [KW-1:0] k, l;
  logic                 tap_v_d;
  logic [DS_W-1:0]      ds, ds_d;

  bif_state_t state, state_next;

  logic [WW-1:0]  eff_w;
  logic [15:0]    eff_h;
  logic [RW-1:0]  eff_r;
  logic           cfg_hit;
  logic           in_fire, out_fire;
  logic           input_done;
  logic           pix_write;
  logic           emit_go;
  logic           col_wrap;
  logic           ocol_wrap;
  logic           is_last;
  logic [23:0]    wpix;

  logic signed [XW-1:0]  x;
  logic signed [YW-1:0]  y;
  logic signed [YSW-1:0] ys;
  logic [SW-1:0]         yslot;
  logic                  tap_ok;
  logic                  tap_issue;
  logic                  walk_end;
  logic [AW-1:0]         waddr, raddr, centre_addr, tap_addr;
  logic [23:0]           rdata;

  logic                  tap_clear;
  logic                  tap_busy;
  logic [2:0][ACC_W-1:0] acc;
  logic [WSUM_W-1:0]     wsum;
  bif_tap_ctl_t          tap_ctl;

  logic                  div_start, div_done;
  logic [2:0][NUM_W-1:0] num;
  logic [2:0][7:0]       quo;
  logic                  load_out;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                     cfg_index == REG_RADIUS || cfg_index == REG_THREE_CH ||
                     cfg_index == REG_COLOR_SCALE || cfg_index == REG_SPACE_SCALE);
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // effective geometry, out of range values folded in
  always_comb begin
    if (image_width == 11'd0) eff_w = WW'(1);
    else if (32'(image_width) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(image_width);
    eff_h = (image_height == 16'd0) ? 16'd1 : image_height;
    eff_r = (32'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius);
  end

  always_comb begin
    input_done = in_row >= eff_h;
    pix_write  = in_fire && (opcode == OP_PIXEL) && !input_done;
    if (opcode == OP_PIXEL) emit_go = pix_write && (in_row >= 16'(eff_r));
    else emit_go = in_fire && input_done && (out_row < eff_h);
    col_wrap  = (COL_W + 1)'(in_column) + 1'b1 >= (COL_W + 1)'(eff_w);
    ocol_wrap = (COL_W + 1)'(out_column) + 1'b1 >= (COL_W + 1)'(eff_w);
    is_last   = (out_row == eff_h - 16'd1) &&
                ((COL_W + 1)'(out_column) == (COL_W + 1)'(eff_w) - 1'b1);
    wpix      = three_channel ? {in_ch2, in_ch1, in_ch0} : {16'd0, in_ch0};
    waddr     = AW'(32'(in_slot) * MAX_WIDTH + 32'(in_column));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd640;
      image_height  <= 16'd480;
      radius        <= 2'd2;
      three_channel <= 1'b0;
      color_scale   <= 24'd65536;
      space_scale   <= 24'd2097152;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:       image_width   <= cfg_data[10:0];
        REG_HEIGHT:      image_height  <= cfg_data[15:0];
        REG_RADIUS:      radius        <= cfg_data[1:0];
        REG_THREE_CH:    three_channel <= cfg_data[0];
        REG_COLOR_SCALE: color_scale   <= cfg_data;
        REG_SPACE_SCALE: space_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster counters; reset, a config write or the start of the frame's last output returns all of them to zero
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_column  <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_slot   <= '0;
    end else begin
      if (pix_write) begin
        if (col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + 16'd1;
          in_slot   <= (in_slot == SW'(SLOTS - 1)) ? '0 : in_slot + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
      end
      if (emit_go) begin
        if (is_last) begin
          in_column  <= '0;
          in_row     <= '0;
          in_slot    <= '0;
          out_column <= '0;
          out_row    <= '0;
          out_slot   <= '0;
        end else if (ocol_wrap) begin
          out_column <= '0;
          out_row    <= out_row + 16'd1;
          out_slot   <= (out_slot == SW'(SLOTS - 1)) ? '0 : out_slot + 1'b1;
        end else begin
          out_column <= out_column + 1'b1;
        end
      end
    end
  end

  // centre capture
  always_ff @(posedge clk) begin
    if (emit_go) begin
      ci    <= out_column;
      cj    <= out_row;
      cslot <= out_slot;
      flast <= is_last;
    end
    if (state == ST_CWAIT) begin
      centre <= rdata;
    end
  end

  // tap position: circle test, image bounds, ring slot
  always_comb begin
    ds       = DS_W'(32'(k) * 32'(k)) + DS_W'(32'(l) * 32'(l));
    x        = XW'(signed'({1'b0, ci})) + XW'(k);
    y        = YW'(signed'({1'b0, cj})) + YW'(l);
    ys       = YSW'(signed'({1'b0, cslot})) + YSW'(l);
    if (ys < 0) yslot = SW'(ys + YSW'(SLOTS));
    else if (ys >= YSW'(SLOTS)) yslot = SW'(ys - YSW'(SLOTS));
    else yslot = SW'(ys);
    tap_ok   = (32'(ds) <= 32'(eff_r) * 32'(eff_r)) && (x >= 0) &&
               (x < XW'(signed'({1'b0, eff_w}))) && (y >= 0) &&
               (y < YW'(signed'({1'b0, eff_h})));
    tap_addr    = AW'(32'(yslot) * MAX_WIDTH + 32'(x[COL_W-1:0]));
    centre_addr = AW'(32'(cslot) * MAX_WIDTH + 32'(ci));
    walk_end    = (k == KW'(signed'({1'b0, eff_r}))) && (l == KW'(signed'({1'b0, eff_r})));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (emit_go) state_next = ST_CENTRE;
      ST_CENTRE: state_next = ST_CWAIT;
      ST_CWAIT:  state_next = ST_TAPS;
      ST_TAPS:   if (walk_end) state_next = ST_FLUSH;
      ST_FLUSH:  if (!tap_v_d && !tap_busy) state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    tap_issue = 1'b0;
    tap_clear = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    raddr     = tap_addr;
    case (state)
      ST_CENTRE: raddr = centre_addr;
      ST_CWAIT:  tap_clear = 1'b1;
      ST_TAPS:   tap_issue = tap_ok;
      ST_FLUSH:  div_start = !tap_v_d && !tap_busy;
      ST_DONE:   load_out = !out_valid || out_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      state   <= ST_IDLE;
      tap_v_d <= 1'b0;
    end else begin
      state   <= state_next;
      tap_v_d <= tap_issue;
    end
  end

  // window walk, row by row from the top left corner
  always_ff @(posedge clk) begin
    ds_d <= ds;
    if (state == ST_CWAIT) begin
      k <= -KW'(signed'({1'b0, eff_r}));
      l <= -KW'(signed'({1'b0, eff_r}));
    end else if (state == ST_TAPS) begin
      if (k == KW'(signed'({1'b0, eff_r}))) begin
        k <= -KW'(signed'({1'b0, eff_r}));
        l <= l + 1'b1;
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  bif_line_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (pix_write),
    .waddr(waddr),
    .wdata(wpix),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    tap_ctl.three_ch    = three_channel;
    tap_ctl.color_scale = color_scale;
    tap_ctl.space_scale = space_scale;
    tap_ctl.centre      = centre;
  end

  bif_tap_unit #(
    .FRACTION_TABLE_DEPTH(FRACTION_TABLE_DEPTH),
    .DS_W                (DS_W),
    .WSUM_W              (WSUM_W),
    .ACC_W               (ACC_W)
  ) u_tap (
    .clk      (clk),
    .rst      (rst),
    .clear    (tap_clear),
    .ctl      (tap_ctl),
    .tap_valid(tap_v_d),
    .px       (rdata),
    .ds       (ds_d),
    .busy     (tap_busy),
    .acc      (acc),
    .wsum     (wsum)
  );

  // round to nearest: add half the weight sum before dividing
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = NUM_W'(acc[c]) + NUM_W'(wsum >> 1);
    end
  end

  bif_divider #(
    .NUM_W(NUM_W),
    .DEN_W(WSUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (wsum),
    .done (div_done),
    .quo  (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch0    <= quo[0];
      out_ch1    <= three_channel ? quo[1] : 8'd0;
      out_ch2    <= three_channel ? quo[2] : 8'd0;
      frame_last <= flast;
    end
  end

  // checks
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (in_row == 16'd0 && out_row == 16'd0 && in_column == '0))
    else $error("config write did not restart the frame");

  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    out_row <= in_row)
    else $error("output row ran ahead of input row");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!tap_busy && !tap_v_d))
    else $error("tap pipeline active while idle");

  a_div_clean: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

endmodule

// File: hdl/bif_line_store.sv
`timescale 1ns / 1ps
// line ring memory: one write port, one registered read port
// no package dependencies

module bif_line_store #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bif_tap_unit.sv
`timescale 1ns / 1ps
// pipelined weight and accumulate unit, one window tap per cycle
// depends on bif_pkg

module bif_tap_unit #(
  parameter int FRACTION_TABLE_DEPTH = 256,
  parameter int DS_W                 = 5,
  parameter int WSUM_W               = 22,
  parameter int ACC_W                = 30
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  bif_pkg::bif_tap_ctl_t    ctl,
  input  logic                     tap_valid,
  input  logic [23:0]              px,
  input  logic [DS_W-1:0]          ds,
  output logic                     busy,
  output logic [2:0][ACC_W-1:0]    acc,
  output logic [WSUM_W-1:0]        wsum
);
  import bif_pkg::*;

  localparam int IDX_W  = $clog2(FRACTION_TABLE_DEPTH);
  localparam int PC_W   = SCALE_W + DC_W;
  localparam int PS_W   = SCALE_W + DS_W;
  localparam int EW     = ((PC_W > PS_W) ? PC_W : PS_W) + 1;
  localparam int IDXP_W = SCALE_W + IDX_W + 1;

  logic [15:0] ftab [FRACTION_TABLE_DEPTH];

  for (genvar g = 0; g < FRACTION_TABLE_DEPTH; g++) begin : g_tab
    assign ftab[g] = frac_value((64'(g) * LN2_Q32) / FRACTION_TABLE_DEPTH);
  end

  logic [7:1]             v;
  logic [2:0][15:0]       sq1;
  logic [DS_W-1:0]        ds1, ds2;
  logic [DC_W-1:0]        dc2;
  logic [PC_W-1:0]        pc3;
  logic [PS_W-1:0]        ps3;
  logic [EW-1:0]          e4;
  logic                   over5;
  logic [4:0]             ip5;
  logic [IDX_W-1:0]       idx5;
  logic [15:0]            wt6, wt7;
  logic [2:0][23:0]       p7;
  logic [23:0]            ch1, ch2, ch3, ch4, ch5, ch6;
  logic [IDXP_W-1:0]      idx_prod;
  logic                   over4;

  assign busy = |v;

  always_comb begin
    idx_prod = IDXP_W'(e4[SCALE_W-1:0]) * IDXP_W'(FRACTION_TABLE_DEPTH);
    over4    = e4 > (EW'(16) << SCALE_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[6:1], tap_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] d;
      a = px[8*c +: 8];
      b = ctl.centre[8*c +: 8];
      d = (a > b) ? (a - b) : (b - a);
      sq1[c] <= (c == 0 || ctl.three_ch) ? 16'(d * d) : 16'd0;
    end
    ch1 <= px;
    ds1 <= ds;

    dc2 <= DC_W'(sq1[0]) + DC_W'(sq1[1]) + DC_W'(sq1[2]);
    ds2 <= ds1;
    ch2 <= ch1;

    pc3 <= PC_W'(ctl.color_scale) * PC_W'(dc2);
    ps3 <= PS_W'(ctl.space_scale) * PS_W'(ds2);
    ch3 <= ch2;

    e4  <= EW'(pc3) + EW'(ps3);
    ch4 <= ch3;

    over5 <= over4;
    ip5   <= e4[SCALE_W +: 5];
    idx5  <= IDX_W'(idx_prod >> SCALE_W);
    ch5   <= ch4;

    wt6 <= over5 ? 16'd0 : (ftab[idx5] >> ip5);
    ch6 <= ch5;

    wt7 <= wt6;
    for (int c = 0; c < 3; c++) begin
      p7[c] <= 24'(wt6) * 24'(ch6[8*c +: 8]);
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (clear) begin
      acc  <= '0;
      wsum <= '0;
    end else if (v[7]) begin
      wsum <= wsum + WSUM_W'(wt7);
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] + ACC_W'(p7[c]);
      end
    end
  end

endmodule

// File: hdl/bif_divider.sv
`timescale 1ns / 1ps
// three-lane restoring divider, 8-bit quotients, one bit a cycle
// no package dependencies

module bif_divider #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 22
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]      den,
  output logic                  done,
  output logic [2:0][7:0]       quo
);

  logic [2:0][NUM_W-1:0] rem;
  logic [NUM_W-1:0]      dsh;
  logic [2:0]            cnt;
  logic                  run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 3'd7;
      end else if (run) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'(den) << 7;
      quo <= '0;
    end else if (run) begin
      dsh <= dsh >> 1;
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= dsh) begin
          rem[c] <= rem[c] - dsh;
          quo[c] <= {quo[c][6:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][6:0], 1'b0};
        end
      end
    end
  end

endmodule
